[hw/rtl/nmea_rmc_pkg.sv]
// ============================================================================
// NMEA RMC parser package
// Character codes, field widths, conversion kinds and shared types for the
// RMC position parser.
// ============================================================================
package nmea_rmc_pkg;

  localparam int FRAC_DIGITS_DEF = 4;
  localparam int FIELD_CHARS_DEF = 12;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_V      = 8'h56;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam int INT_W   = 17;
  localparam int LAT_W   = 27;
  localparam int LON_W   = 28;
  localparam int MICRO_W = 30;

  localparam logic [INT_W-1:0]   INT_ACC_MAX = 17'd99999;
  localparam logic [MICRO_W-1:0] LAT_MAX     = 30'd90000000;
  localparam logic [MICRO_W-1:0] LON_MAX     = 30'd180000000;

  localparam logic [1:0] KIND_LAT  = 2'd0;
  localparam logic [1:0] KIND_LON  = 2'd1;
  localparam logic [1:0] KIND_VOID = 2'd2;

  typedef struct packed {
    logic       vld;
    logic [1:0] kind;
  } conv_req_t;

  typedef struct packed {
    logic             vld;
    logic [1:0]       kind;
    logic [LON_W-1:0] micro;
  } conv_rsp_t;

  typedef struct packed {
    logic             fix_valid;
    logic [7:0]       status_char;
    logic [LAT_W-1:0] latitude_microdeg;
    logic [LON_W-1:0] longitude_microdeg;
  } result_t;

  function automatic int unsigned pow10(input int n);
    int unsigned v;
    v = 1;
    for (int i = 0; i < n; i++) begin
      v = v * 10;
    end
    return v;
  endfunction

endpackage

[hw/rtl/nmea_rmc_if.sv]
// ============================================================================
// NMEA RMC parser channels
// Valid/ready channels for received bytes and for position results.
// ============================================================================
interface nmea_rmc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface nmea_rmc_out_if;
  logic        valid;
  logic        ready;
  logic        fix_valid;
  logic [7:0]  status_char;
  logic [26:0] latitude_microdeg;
  logic [27:0] longitude_microdeg;

  modport source (output valid, output fix_valid, output status_char,
                  output latitude_microdeg, output longitude_microdeg, input ready);
  modport sink (input valid, input fix_valid, input status_char,
                input latitude_microdeg, input longitude_microdeg, output ready);
endinterface

[hw/rtl/nmea_rmc_conv.sv]
// ============================================================================
// NMEA RMC coordinate converter
// Pipelined conversion of a dddmm.mmmm field into saturated millionths of a
// degree, using reciprocal multiplies for the divisions by 100 and by 60.
// ============================================================================
module nmea_rmc_conv
  import nmea_rmc_pkg::*;
#(
  parameter int FRAC_DIGITS = FRAC_DIGITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  conv_req_t                              req,
  input  logic [INT_W-1:0]                       req_int,
  input  logic [$clog2(pow10(FRAC_DIGITS))-1:0]  req_frac,
  input  logic [$clog2(FRAC_DIGITS+1)-1:0]       req_cnt,
  output conv_rsp_t                              rsp,
  output logic [2:0]                             pend_cnt
);

  localparam int SCALE  = pow10(FRAC_DIGITS);
  localparam int FW     = $clog2(SCALE);
  localparam int CW     = $clog2(FRAC_DIGITS + 1);
  localparam int PW     = $clog2(SCALE + 1);
  localparam int KMUL   = 1000000 / SCALE;
  localparam int STAGES = 6;

  localparam logic [20:0] RECIP_25 = 21'd1342178;
  localparam logic [29:0] RECIP_15 = 30'd572662307;

  logic [STAGES-1:0] vld_r;
  logic [1:0]        kind_r [STAGES];

  logic [INT_W-1:0]   int0_r;
  logic [FW-1:0]      frac0_r;
  logic [CW-1:0]      cnt0_r;

  logic [35:0]        q1_r;
  logic [INT_W-1:0]   int1_r;
  logic [FW-1:0]      fpad1_r;

  logic [9:0]         deg2_r;
  logic [6:0]         minw2_r;
  logic [FW-1:0]      fpad2_r;

  logic [26:0]        x3_r;
  logic [MICRO_W-1:0] degm3_r;

  logic [54:0]        p4_r;
  logic [MICRO_W-1:0] degm4_r;

  logic [LON_W-1:0]   micro5_r;

  logic [PW-1:0]      pad;
  logic [FW+PW-1:0]   fpad_full;
  logic [9:0]         deg_nxt;
  logic [INT_W-1:0]   minw_full;
  logic [MICRO_W-1:0] micro_sum;
  logic [MICRO_W-1:0] micro_lim;
  logic [MICRO_W-1:0] micro_sat;

  always_comb begin
    pad = '0;
    for (int i = 0; i <= FRAC_DIGITS; i++) begin
      if (cnt0_r == CW'(i)) begin
        pad = PW'(pow10(FRAC_DIGITS - i));
      end
    end
    fpad_full = (FW+PW)'(frac0_r) * (FW+PW)'(pad);
  end

  assign deg_nxt   = q1_r[34:25];
  assign minw_full = int1_r - INT_W'(INT_W'(deg_nxt) * INT_W'(100));

  assign micro_sum = degm4_r + MICRO_W'(p4_r[54:33]);
  assign micro_lim = (kind_r[4] == KIND_LAT) ? LAT_MAX : LON_MAX;
  assign micro_sat = (micro_sum > micro_lim) ? micro_lim : micro_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[STAGES-2:0], req.vld};
    end
  end

  always_ff @(posedge clk) begin
    kind_r[0] <= req.kind;
    for (int s = 1; s < STAGES; s++) begin
      kind_r[s] <= kind_r[s-1];
    end

    int0_r  <= req_int;
    frac0_r <= req_frac;
    cnt0_r  <= req_cnt;

    q1_r    <= 36'(int0_r[INT_W-1:2]) * 36'(RECIP_25);
    int1_r  <= int0_r;
    fpad1_r <= fpad_full[FW-1:0];

    deg2_r  <= deg_nxt;
    minw2_r <= minw_full[6:0];
    fpad2_r <= fpad1_r;

    x3_r    <= 27'(minw2_r) * 27'd1000000 + 27'(fpad2_r) * 27'(KMUL);
    degm3_r <= MICRO_W'(deg2_r) * MICRO_W'(1000000);

    p4_r    <= 55'(x3_r[26:2]) * 55'(RECIP_15);
    degm4_r <= degm3_r;

    micro5_r <= micro_sat[LON_W-1:0];
  end

  always_comb begin
    pend_cnt = '0;
    for (int s = 0; s < STAGES; s++) begin
      if (vld_r[s] && kind_r[s] != KIND_LAT) begin
        pend_cnt = pend_cnt + 3'd1;
      end
    end
  end

  assign rsp.vld   = vld_r[STAGES-1];
  assign rsp.kind  = kind_r[STAGES-1];
  assign rsp.micro = micro5_r;

endmodule

[hw/rtl/nmea_rmc_position_parser_core.sv]
// ============================================================================
// NMEA RMC position parser
// Matches $GPRMC sentences byte by byte, captures the status byte and turns
// the latitude and longitude fields into millionths of a degree.
//
// Channel  Direction  Transfer
// in_if    sink       one received ASCII byte (rx_byte)
// out_if   source     fix_valid, status_char, latitude and longitude
//
// One byte is taken per cycle while in_if.ready is high. A result is completed
// by a V status byte or by the comma after the longitude, passes through the
// converter pipeline and then waits in a two-entry output buffer.
// Reset is synchronous and returns the parser to waiting for a dollar sign.
// in_if.ready drops only while the output buffer and the results still in
// the converter could fill it; out_if.ready never reaches in_if.ready.
// ============================================================================
module nmea_rmc_position_parser_core
  import nmea_rmc_pkg::*;
#(
  parameter int FRAC_DIGITS = FRAC_DIGITS_DEF,
  parameter int FIELD_CHARS = FIELD_CHARS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  nmea_rmc_in_if.sink    in_if,
  nmea_rmc_out_if.source out_if
);

  localparam int FW  = $clog2(pow10(FRAC_DIGITS));
  localparam int CW  = $clog2(FRAC_DIGITS + 1);
  localparam int CCW = $clog2(FIELD_CHARS);

  localparam logic [3:0] PH_IDLE        = 4'd0;
  localparam logic [3:0] PH_G           = 4'd1;
  localparam logic [3:0] PH_P           = 4'd2;
  localparam logic [3:0] PH_R           = 4'd3;
  localparam logic [3:0] PH_M           = 4'd4;
  localparam logic [3:0] PH_C           = 4'd5;
  localparam logic [3:0] PH_SKIP_COMMA1 = 4'd6;
  localparam logic [3:0] PH_TIME        = 4'd7;
  localparam logic [3:0] PH_STATUS      = 4'd8;
  localparam logic [3:0] PH_SKIP_COMMA2 = 4'd9;
  localparam logic [3:0] PH_LAT         = 4'd10;
  localparam logic [3:0] PH_SKIP_HEMI   = 4'd11;
  localparam logic [3:0] PH_SKIP_COMMA3 = 4'd12;
  localparam logic [3:0] PH_LON         = 4'd13;

  logic [3:0]       phase_r, phase_nxt;
  logic [INT_W-1:0] int_acc_r, int_acc_nxt;
  logic [FW-1:0]    frac_acc_r, frac_acc_nxt;
  logic [CW-1:0]    frac_cnt_r, frac_cnt_nxt;
  logic             dot_seen_r, dot_seen_nxt;
  logic [CCW-1:0]   char_cnt_r, char_cnt_nxt;
  logic [7:0]       status_hold_r, status_hold_nxt;
  logic [LAT_W-1:0] lat_hold_r;

  logic             in_fire;
  logic [7:0]       rx;
  logic             is_digit;
  logic [3:0]       dval;
  logic [19:0]      acc10;
  logic [FW+3:0]    frac10;

  logic [INT_W-1:0] take_int;
  logic [FW-1:0]    take_frac;
  logic [CW-1:0]    take_cnt;
  logic             take_dot;
  logic [CCW-1:0]   take_chars;

  conv_req_t        req;
  conv_rsp_t        rsp;
  logic [2:0]       pend_cnt;

  result_t          ent_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       fifo_cnt_r;
  logic             push;
  logic             pop;
  result_t          push_data;

  assign rx      = in_if.rx_byte;
  assign in_fire = in_if.valid && in_if.ready;
  assign in_if.ready = (4'(fifo_cnt_r) + 4'(pend_cnt)) < 4'd2;

  assign is_digit = (rx >= CH_ZERO) && (rx <= CH_NINE);
  assign dval     = 4'(rx - CH_ZERO);
  assign acc10    = 20'(int_acc_r) * 20'd10 + 20'(dval);
  assign frac10   = (FW+4)'(frac_acc_r) * (FW+4)'(10) + (FW+4)'(dval);

  always_comb begin
    take_int   = int_acc_r;
    take_frac  = frac_acc_r;
    take_cnt   = frac_cnt_r;
    take_dot   = dot_seen_r;
    take_chars = char_cnt_r;
    if (char_cnt_r < CCW'(FIELD_CHARS - 1)) begin
      take_chars = char_cnt_r + CCW'(1);
      if (is_digit) begin
        if (!dot_seen_r) begin
          take_int = (acc10 > 20'(INT_ACC_MAX)) ? INT_ACC_MAX : acc10[INT_W-1:0];
        end else if (frac_cnt_r < CW'(FRAC_DIGITS)) begin
          take_frac = frac10[FW-1:0];
          take_cnt  = frac_cnt_r + CW'(1);
        end
      end else if (rx == CH_DOT) begin
        take_dot = 1'b1;
      end
    end
  end

  always_comb begin
    phase_nxt       = phase_r;
    int_acc_nxt     = int_acc_r;
    frac_acc_nxt    = frac_acc_r;
    frac_cnt_nxt    = frac_cnt_r;
    dot_seen_nxt    = dot_seen_r;
    char_cnt_nxt    = char_cnt_r;
    status_hold_nxt = status_hold_r;
    req             = '0;
    if (in_fire) begin
      unique case (phase_r) inside
        PH_IDLE: begin
          if (rx == CH_DOLLAR) begin
            phase_nxt = PH_G;
          end
        end
        PH_G: phase_nxt = (rx == CH_G) ? PH_P : PH_IDLE;
        PH_P: phase_nxt = (rx == CH_P) ? PH_R : PH_IDLE;
        PH_R: phase_nxt = (rx == CH_R) ? PH_M : PH_IDLE;
        PH_M: phase_nxt = (rx == CH_M) ? PH_C : PH_IDLE;
        PH_C: phase_nxt = (rx == CH_C) ? PH_SKIP_COMMA1 : PH_IDLE;
        PH_SKIP_COMMA1: phase_nxt = PH_TIME;
        PH_TIME: begin
          if (rx == CH_COMMA) begin
            phase_nxt = PH_STATUS;
          end
        end
        PH_STATUS: begin
          status_hold_nxt = rx;
          if (rx == CH_V) begin
            phase_nxt = PH_IDLE;
            req.vld   = 1'b1;
            req.kind  = KIND_VOID;
          end else begin
            phase_nxt = PH_SKIP_COMMA2;
          end
        end
        PH_SKIP_COMMA2, PH_SKIP_COMMA3: begin
          int_acc_nxt  = '0;
          frac_acc_nxt = '0;
          frac_cnt_nxt = '0;
          dot_seen_nxt = 1'b0;
          char_cnt_nxt = '0;
          phase_nxt    = (phase_r == PH_SKIP_COMMA2) ? PH_LAT : PH_LON;
        end
        PH_LAT, PH_LON: begin
          if (rx == CH_COMMA) begin
            req.vld      = 1'b1;
            req.kind     = (phase_r == PH_LAT) ? KIND_LAT : KIND_LON;
            int_acc_nxt  = '0;
            frac_acc_nxt = '0;
            frac_cnt_nxt = '0;
            dot_seen_nxt = 1'b0;
            char_cnt_nxt = '0;
            phase_nxt    = (phase_r == PH_LAT) ? PH_SKIP_HEMI : PH_IDLE;
          end else begin
            int_acc_nxt  = take_int;
            frac_acc_nxt = take_frac;
            frac_cnt_nxt = take_cnt;
            dot_seen_nxt = take_dot;
            char_cnt_nxt = take_chars;
          end
        end
        PH_SKIP_HEMI: phase_nxt = PH_SKIP_COMMA3;
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      int_acc_r     <= '0;
      frac_acc_r    <= '0;
      frac_cnt_r    <= '0;
      dot_seen_r    <= 1'b0;
      char_cnt_r    <= '0;
      status_hold_r <= '0;
    end else begin
      phase_r       <= phase_nxt;
      int_acc_r     <= int_acc_nxt;
      frac_acc_r    <= frac_acc_nxt;
      frac_cnt_r    <= frac_cnt_nxt;
      dot_seen_r    <= dot_seen_nxt;
      char_cnt_r    <= char_cnt_nxt;
      status_hold_r <= status_hold_nxt;
    end
  end

  nmea_rmc_conv #(
    .FRAC_DIGITS(FRAC_DIGITS)
  ) u_conv (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .req_int  (int_acc_r),
    .req_frac (frac_acc_r),
    .req_cnt  (frac_cnt_r),
    .rsp      (rsp),
    .pend_cnt (pend_cnt)
  );

  assign push = rsp.vld && (rsp.kind == KIND_LON || rsp.kind == KIND_VOID);
  assign pop  = out_if.valid && out_if.ready;

  always_comb begin
    push_data.status_char = status_hold_r;
    if (rsp.kind == KIND_LON) begin
      push_data.fix_valid          = 1'b1;
      push_data.latitude_microdeg  = lat_hold_r;
      push_data.longitude_microdeg = rsp.micro;
    end else begin
      push_data.fix_valid          = 1'b0;
      push_data.latitude_microdeg  = '0;
      push_data.longitude_microdeg = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_hold_r <= '0;
      wr_ptr_r   <= 1'b0;
      rd_ptr_r   <= 1'b0;
      fifo_cnt_r <= '0;
    end else begin
      if (rsp.vld && rsp.kind == KIND_LAT) begin
        lat_hold_r <= rsp.micro[LAT_W-1:0];
      end
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      fifo_cnt_r <= fifo_cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  assign out_if.valid              = fifo_cnt_r != 2'd0;
  assign out_if.fix_valid          = ent_r[rd_ptr_r].fix_valid;
  assign out_if.status_char        = ent_r[rd_ptr_r].status_char;
  assign out_if.latitude_microdeg  = ent_r[rd_ptr_r].latitude_microdeg;
  assign out_if.longitude_microdeg = ent_r[rd_ptr_r].longitude_microdeg;

endmodule
